>>> rtl/nwmm_pkg.sv
// Shared types and constants of the normal-weighted masked mean filter.
`default_nettype none
package nwmm_pkg;
	localparam int COLOR_W = 16;
	localparam int TAG_W   = 16;
	localparam int NRM_W   = 16;
	localparam int H_W     = 13;
	localparam int IW_W    = 11;
	localparam int WS_W    = 4;
	localparam int RAD_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WFRAC   = 14;
	localparam int WONE    = 16384;
	localparam int PROD_W  = 2 * NRM_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int WT_W    = DOT_W - WFRAC;
	localparam int MUL_W   = COLOR_W + 1 + WT_W;
	localparam int SUM_W   = 48;
	localparam int WSUM_W  = 32;
	localparam int NCH     = 3;
	localparam int DRAIN_LEN = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

	typedef struct packed {
		logic [COLOR_W-1:0]       r;
		logic [COLOR_W-1:0]       g;
		logic [COLOR_W-1:0]       b;
		logic [TAG_W-1:0]         tag;
		logic signed [NRM_W-1:0]  nx;
		logic signed [NRM_W-1:0]  ny;
		logic signed [NRM_W-1:0]  nz;
	} pix_t;

	localparam int PIX_W = $bits(pix_t);

	typedef struct packed {
		logic init;
		logic sample;
	} acc_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDC,
		ST_CAP,
		ST_LOOP,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

>>> rtl/nwmm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module nwmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/nwmm_acc.sv
// Weight and accumulate pipeline for window neighbors.
`default_nettype none
module nwmm_acc (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire nwmm_pkg::acc_ctl_t         ctl,
	input  wire nwmm_pkg::pix_t             center,
	input  wire nwmm_pkg::pix_t             nbr,
	output logic signed [nwmm_pkg::SUM_W-1:0]  sum_r,
	output logic signed [nwmm_pkg::SUM_W-1:0]  sum_g,
	output logic signed [nwmm_pkg::SUM_W-1:0]  sum_b,
	output logic signed [nwmm_pkg::WSUM_W-1:0] wsum
);
	import nwmm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0] p_s2 [NCH];
	logic [COLOR_W-1:0] c_s2 [NCH];
	logic [COLOR_W-1:0] c_s3 [NCH];
	logic signed [WT_W-1:0] wt_s3, wt_s4;
	logic signed [MUL_W-1:0] m_s4 [NCH];
	logic signed [SUM_W-1:0] sum_q [NCH];
	logic signed [WSUM_W-1:0] wsum_q;
	logic signed [DOT_W-1:0] dot, dotb;

	always_comb begin
		dot = DOT_W'(p_s2[0]) + DOT_W'(p_s2[1]) + DOT_W'(p_s2[2]);
		// truncate toward zero
		dotb = dot + (dot[DOT_W-1] ? DOT_W'(WONE - 1) : DOT_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.sample;
			v_s2 <= v_s1 && (nbr.tag == center.tag);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s2[0] <= center.nx * nbr.nx;
		p_s2[1] <= center.ny * nbr.ny;
		p_s2[2] <= center.nz * nbr.nz;
		c_s2[0] <= nbr.r;
		c_s2[1] <= nbr.g;
		c_s2[2] <= nbr.b;
		wt_s3 <= dotb[DOT_W-1:WFRAC];
		c_s3 <= c_s2;
		wt_s4 <= wt_s3;
		for (int k = 0; k < NCH; k++) begin
			m_s4[k] <= $signed({1'b0, c_s3[k]}) * wt_s3;
		end
		if (ctl.init) begin
			// during init the read port still carries the center pixel
			sum_q[0] <= SUM_W'({nbr.r, WFRAC'(0)});
			sum_q[1] <= SUM_W'({nbr.g, WFRAC'(0)});
			sum_q[2] <= SUM_W'({nbr.b, WFRAC'(0)});
			wsum_q <= WSUM_W'(WONE);
		end else if (v_s4) begin
			for (int k = 0; k < NCH; k++) begin
				sum_q[k] <= sum_q[k] + SUM_W'(m_s4[k]);
			end
			wsum_q <= wsum_q + WSUM_W'(wt_s4);
		end
	end

	assign sum_r = sum_q[0];
	assign sum_g = sum_q[1];
	assign sum_b = sum_q[2];
	assign wsum  = wsum_q;
endmodule
`default_nettype wire

>>> rtl/nwmm_div.sv
// Three-lane restoring divider, one quotient bit per cycle, clamped to 16 bits.
`default_nettype none
module nwmm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [nwmm_pkg::SUM_W-1:0]    num_r,
	input  wire logic [nwmm_pkg::SUM_W-1:0]    num_g,
	input  wire logic [nwmm_pkg::SUM_W-1:0]    num_b,
	input  wire logic [nwmm_pkg::WSUM_W-1:0]   den,
	output logic                               done,
	output logic [nwmm_pkg::COLOR_W-1:0]       quo_r,
	output logic [nwmm_pkg::COLOR_W-1:0]       quo_g,
	output logic [nwmm_pkg::COLOR_W-1:0]       quo_b
);
	import nwmm_pkg::*;
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  num_q [NCH];
	logic [WSUM_W:0]   rem_q [NCH];
	logic [WSUM_W:0]   trial [NCH];
	logic              ge [NCH];
	logic [WSUM_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [COLOR_W-1:0] q [NCH];

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			trial[k] = {rem_q[k][WSUM_W-1:0], num_q[k][SUM_W-1]};
			ge[k] = trial[k] >= {1'b0, den_q};
			q[k] = (num_q[k][SUM_W-1:COLOR_W] != '0) ? '1 : num_q[k][COLOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q[0] <= num_r;
			num_q[1] <= num_g;
			num_q[2] <= num_b;
			den_q <= den;
			for (int k = 0; k < NCH; k++) begin
				rem_q[k] <= '0;
			end
		end else if (busy_q) begin
			for (int k = 0; k < NCH; k++) begin
				rem_q[k] <= ge[k] ? trial[k] - {1'b0, den_q} : trial[k];
				num_q[k] <= {num_q[k][SUM_W-2:0], ge[k]};
			end
		end
	end

	assign done  = done_q;
	assign quo_r = q[0];
	assign quo_g = q[1];
	assign quo_b = q[2];
endmodule
`default_nettype wire

>>> rtl/normal_weighted_masked_mean_core.sv
// Top level of the normal-weighted, object-masked mean filter.
// Pixels enter in raster order on the input channel (in_valid / in_stall),
// op = 0 carries a pixel, op = 1 is a flush tick. Every pixel is written
// to a line ring in one RAM; once radius rows plus radius pixels are
// buffered, each new pixel releases one filtered output for the pixel that
// trails it. Once the whole frame is in, each flush tick drains one more.
// A transfer that releases an output holds the input (in_stall high) while
// the center pixel is read, each window neighbor is read from the RAM, the
// weight pipeline drains, the bit-serial divider runs if the weight sum is
// positive and the output register is loaded. A transfer that releases
// nothing does not hold the input. Radius 0 (window_size at most 1) needs
// only the center read.
// The output register decouples the sides: input keeps flowing while a
// result waits under out_stall; only a second result waits for it.
// Reset clears counters and handshake state; the RAM holds no reset value
// and needs none, since only entries of the current frame are read.
// Configuration writes (cfg_write) take effect at once and restart the frame.
`default_nettype none
module normal_weighted_masked_mean_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7,
	parameter int STORE_ROWS = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [nwmm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [nwmm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                op,
	input  wire logic [nwmm_pkg::COLOR_W-1:0]        red_in,
	input  wire logic [nwmm_pkg::COLOR_W-1:0]        green_in,
	input  wire logic [nwmm_pkg::COLOR_W-1:0]        blue_in,
	input  wire logic [nwmm_pkg::TAG_W-1:0]          object_tag,
	input  wire logic signed [nwmm_pkg::NRM_W-1:0]   normal_x,
	input  wire logic signed [nwmm_pkg::NRM_W-1:0]   normal_y,
	input  wire logic signed [nwmm_pkg::NRM_W-1:0]   normal_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [nwmm_pkg::COLOR_W-1:0]             red_out,
	output logic [nwmm_pkg::COLOR_W-1:0]             green_out,
	output logic [nwmm_pkg::COLOR_W-1:0]             blue_out,
	output logic                                     weight_invalid,
	output logic                                     frame_end
);
	import nwmm_pkg::*;

	localparam int D    = STORE_ROWS * MAX_WIDTH;
	localparam int AW   = $clog2(D);
	localparam int SW   = AW + 2;
	localparam int XW   = $clog2(MAX_WIDTH + 1);
	localparam int CW   = XW + H_W;
	localparam int RL1  = (MAX_RADIUS < (STORE_ROWS - 1) / 2) ? MAX_RADIUS
		: (STORE_ROWS - 1) / 2;
	localparam int RLIM = (RL1 < (MAX_WIDTH - 1) / 2) ? RL1 : (MAX_WIDTH - 1) / 2;

	// configuration
	logic [IW_W-1:0] iw_q;
	logic [H_W-1:0]  ih_q;
	logic [WS_W-1:0] ws_q;

	logic [XW-1:0]    effw;
	logic [H_W-1:0]   effh;
	logic [RAD_W-1:0] rad;
	logic [CW-1:0]    total, lag;

	always_comb begin
		if (iw_q == '0) begin
			effw = XW'(1);
		end else if (32'(iw_q) > MAX_WIDTH) begin
			effw = XW'(MAX_WIDTH);
		end else begin
			effw = XW'(iw_q);
		end
		effh = (ih_q == '0) ? H_W'(1) : ih_q;
		if (ws_q <= WS_W'(1)) begin
			rad = '0;
		end else if (32'(ws_q >> 1) > RLIM) begin
			rad = RAD_W'(RLIM);
		end else begin
			rad = RAD_W'(ws_q >> 1);
		end
		total = CW'(effw) * CW'(effh);
		lag   = CW'(rad) * CW'(effw) + CW'(rad);
	end

	// frame counters and ring pointers
	state_t state_q, state_d;
	logic [CW-1:0] acc_q, emit_q;
	logic [AW-1:0] waddr_q, eaddr_q, rowaddr_q;
	logic [XW-1:0] ex_q;
	logic [H_W-1:0] ey_q;
	logic signed [RAD_W:0] dx_q, dy_q;
	logic [2:0] cnt_q;
	pix_t cen_q;
	logic [COLOR_W-1:0] res_q [NCH];
	logic inv_q;
	logic neg_q [NCH];

	logic [CW-1:0] acc_inc, emit_inc;
	logic go, out_free;
	logic signed [RAD_W:0] rpos, rneg;
	logic last;

	always_comb begin
		acc_inc  = acc_q + 1'b1;
		emit_inc = emit_q + 1'b1;
		if (op) begin
			go = (acc_q >= total) && (emit_q < acc_q);
		end else begin
			go = (acc_q < total) && ((acc_inc - emit_q) > lag);
		end
		out_free = !out_valid || !out_stall;
		rpos = $signed({1'b0, rad});
		rneg = -rpos;
		last = (dx_q == rpos) && (dy_q == rpos);
	end

	// ring address arithmetic
	logic [SW-1:0] rw;
	logic signed [SW-1:0] t_init, t_step, t_nbr;
	logic [AW-1:0] row_init, row_next, naddr;
	logic signed [XW+1:0]  px;
	logic signed [H_W+1:0] py;
	logic inb;

	always_comb begin
		rw = SW'(rad) * SW'(effw);
		t_init = $signed({2'b0, eaddr_q}) - $signed(rw);
		if (t_init < 0) begin
			t_init = t_init + $signed(SW'(D));
		end
		row_init = AW'(t_init);
		t_step = $signed({2'b0, rowaddr_q}) + $signed(SW'(effw));
		if (t_step >= $signed(SW'(D))) begin
			t_step = t_step - $signed(SW'(D));
		end
		row_next = AW'(t_step);
		t_nbr = $signed({2'b0, rowaddr_q}) + SW'(dx_q);
		if (t_nbr < 0) begin
			t_nbr = t_nbr + $signed(SW'(D));
		end else if (t_nbr >= $signed(SW'(D))) begin
			t_nbr = t_nbr - $signed(SW'(D));
		end
		naddr = AW'(t_nbr);
		px = $signed({2'b0, ex_q}) + (XW + 2)'(dx_q);
		py = $signed({2'b0, ey_q}) + (H_W + 2)'(dy_q);
		inb = !px[XW+1] && (px < $signed({2'b0, effw}))
			&& !py[H_W+1] && (py < $signed({2'b0, effh}));
	end

	// memory
	logic ram_we;
	logic [AW-1:0] raddr;
	pix_t wpix, rpix;
	logic [PIX_W-1:0] rdata;

	assign wpix = '{r: red_in, g: green_in, b: blue_in, tag: object_tag,
		nx: normal_x, ny: normal_y, nz: normal_z};
	assign rpix = pix_t'(rdata);

	nwmm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (D)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_q),
		.wdata (PIX_W'(wpix)),
		.raddr (raddr),
		.rdata (rdata)
	);

	// weight pipeline and divider
	acc_ctl_t ctl;
	logic signed [SUM_W-1:0] sum [NCH];
	logic signed [WSUM_W-1:0] wsum;
	logic wpos, div_start, div_done;
	logic [SUM_W-1:0] num [NCH];
	logic [COLOR_W-1:0] quo [NCH];

	nwmm_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.center (cen_q),
		.nbr    (rpix),
		.sum_r  (sum[0]),
		.sum_g  (sum[1]),
		.sum_b  (sum[2]),
		.wsum   (wsum)
	);

	always_comb begin
		wpos = !wsum[WSUM_W-1] && (wsum != '0);
		for (int k = 0; k < NCH; k++) begin
			num[k] = sum[k][SUM_W-1] ? '0 : sum[k];
		end
	end

	nwmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_r  (num[0]),
		.num_g  (num[1]),
		.num_b  (num[2]),
		.den    (wsum),
		.done   (div_done),
		.quo_r  (quo[0]),
		.quo_g  (quo[1]),
		.quo_b  (quo[2])
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && go) begin
					state_d = ST_RDC;
				end
			end
			ST_RDC: state_d = ST_CAP;
			ST_CAP: begin
				state_d = (rad == '0) ? ST_DONE : ST_LOOP;
			end
			ST_LOOP: begin
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == 3'(DRAIN_LEN)) begin
					state_d = wpos ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		ram_we     = 1'b0;
		raddr      = naddr;
		ctl.init   = 1'b0;
		ctl.sample = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE:  ram_we = in_valid && !op && (acc_q < total);
			ST_RDC:   raddr = eaddr_q;
			ST_CAP:   ctl.init = 1'b1;
			ST_LOOP:  ctl.sample = inb;
			ST_DRAIN: div_start = (cnt_q == 3'(DRAIN_LEN)) && wpos;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iw_q      <= IW_W'(1024);
			ih_q      <= H_W'(1024);
			ws_q      <= WS_W'(3);
			acc_q     <= '0;
			emit_q    <= '0;
			waddr_q   <= '0;
			eaddr_q   <= '0;
			ex_q      <= '0;
			ey_q      <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_write && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT
				|| cfg_index == CFG_WINDOW)) begin
				case (cfg_index)
					CFG_WIDTH:  iw_q <= cfg_data[IW_W-1:0];
					CFG_HEIGHT: ih_q <= cfg_data[H_W-1:0];
					CFG_WINDOW: ws_q <= cfg_data[WS_W-1:0];
					default: begin
					end
				endcase
				acc_q   <= '0;
				emit_q  <= '0;
				waddr_q <= '0;
				eaddr_q <= '0;
				ex_q    <= '0;
				ey_q    <= '0;
			end else begin
				if (ram_we) begin
					acc_q   <= acc_inc;
					waddr_q <= (32'(waddr_q) == D - 1) ? '0 : waddr_q + 1'b1;
				end
				if (state_q == ST_DRAIN) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					cnt_q <= '0;
				end
				if (state_q == ST_DONE && out_free) begin
					out_valid <= 1'b1;
					if (emit_inc >= total) begin
						// frame drained: start over
						acc_q   <= '0;
						emit_q  <= '0;
						waddr_q <= '0;
						eaddr_q <= '0;
						ex_q    <= '0;
						ey_q    <= '0;
					end else begin
						emit_q  <= emit_inc;
						eaddr_q <= (32'(eaddr_q) == D - 1) ? '0 : eaddr_q + 1'b1;
						if (ex_q + 1'b1 == effw) begin
							ex_q <= '0;
							ey_q <= ey_q + 1'b1;
						end else begin
							ex_q <= ex_q + 1'b1;
						end
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CAP: begin
				cen_q     <= rpix;
				dx_q      <= rneg;
				dy_q      <= rneg;
				rowaddr_q <= row_init;
				res_q[0]  <= rpix.r;
				res_q[1]  <= rpix.g;
				res_q[2]  <= rpix.b;
				inv_q     <= 1'b0;
			end
			ST_LOOP: begin
				if (dx_q == rpos) begin
					dx_q      <= rneg;
					dy_q      <= dy_q + 1'b1;
					rowaddr_q <= row_next;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == 3'(DRAIN_LEN)) begin
					inv_q <= !wpos;
					for (int k = 0; k < NCH; k++) begin
						neg_q[k] <= sum[k][SUM_W-1];
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					for (int k = 0; k < NCH; k++) begin
						res_q[k] <= neg_q[k] ? '0 : quo[k];
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					red_out        <= res_q[0];
					green_out      <= res_q[1];
					blue_out       <= res_q[2];
					weight_invalid <= inv_q;
					frame_end      <= (emit_inc == total);
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire
